// File: rtl/ctlc_pkg.sv
// Package for the C subset token classifier: class codes, character tests,
// keyword table and the queue entry passed from the front end to the back end.
// No dependencies.
package ctlc_pkg;

    localparam int KEYWORD_BYTES           = 8;
    localparam int KEYWORD_COUNT           = 22;
    localparam int DEFAULT_MAX_WORD_LENGTH = 255;
    localparam int QUEUE_DEPTH             = 4;
    localparam int QUEUE_AW                = $clog2(QUEUE_DEPTH);

    localparam logic [3:0] CLASS_KEYWORD    = 4'd0;
    localparam logic [3:0] CLASS_MULTIDOT   = 4'd1;
    localparam logic [3:0] CLASS_INTEGER    = 4'd2;
    localparam logic [3:0] CLASS_FLOAT      = 4'd3;
    localparam logic [3:0] CLASS_IDENT      = 4'd4;
    localparam logic [3:0] CLASS_BAD_IDENT  = 4'd5;
    localparam logic [3:0] CLASS_ARITH      = 4'd6;
    localparam logic [3:0] CLASS_RELATIONAL = 4'd7;
    localparam logic [3:0] CLASS_SEPARATOR  = 4'd8;

    typedef logic [8*KEYWORD_BYTES-1:0] t_kw_word;

    typedef struct packed {
        logic       has_word;
        logic [3:0] word_class;
        logic [7:0] word_len;
        logic       has_sym;
        logic [3:0] sym_class;
        logic [7:0] sym;
    } t_entry;

    // first byte of the word in the top byte, padded with zeros
    localparam t_kw_word KW_TABLE [KEYWORD_COUNT] = '{
        {"if", 48'd0}, {"else", 32'd0}, {"while", 24'd0}, {"do", 48'd0},
        {"break", 24'd0}, "continue", {"int", 40'd0}, {"double", 16'd0},
        {"float", 24'd0}, {"return", 16'd0}, {"char", 32'd0}, {"case", 32'd0},
        {"sizeof", 16'd0}, {"long", 32'd0}, {"short", 24'd0}, {"typedef", 8'd0},
        {"switch", 16'd0}, "unsigned", {"void", 32'd0}, {"static", 16'd0},
        {"struct", 16'd0}, {"goto", 32'd0}
    };

    localparam logic [3:0] KW_LEN [KEYWORD_COUNT] = '{
        4'd2, 4'd4, 4'd5, 4'd2, 4'd5, 4'd8, 4'd3, 4'd6, 4'd5, 4'd6, 4'd4,
        4'd4, 4'd6, 4'd4, 4'd5, 4'd7, 4'd6, 4'd8, 4'd4, 4'd6, 4'd6, 4'd4
    };

    function automatic logic is_keyword(input t_kw_word kw_buf, input logic [3:0] len);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < KEYWORD_COUNT; k++) begin
            if (kw_buf == KW_TABLE[k] && len == KW_LEN[k]) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return c inside {["a":"z"], ["A":"Z"], "_"};
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        return c inside {" ", 8'h0A, "+", "-", "*", "/", ",", ";", "<", ">", "=",
                         "(", ")", "[", "]", "{", "}"};
    endfunction

    function automatic logic [4:0] sym_kind(input logic [7:0] c);
        logic [4:0] r;
        r = {1'b0, CLASS_KEYWORD};
        if (c inside {"+", "-", "*", "/"}) begin
            r = {1'b1, CLASS_ARITH};
        end else if (c inside {"<", ">", "="}) begin
            r = {1'b1, CLASS_RELATIONAL};
        end else if (c inside {",", ";", "(", ")", "{", "}"}) begin
            r = {1'b1, CLASS_SEPARATOR};
        end
        return r;
    endfunction

endpackage

// File: rtl/ctlc_front.sv
// Front end: collects word state per character and classifies words and delimiters.
// Pushes one queue entry per closing delimiter or end marker with a word or reportable symbol. Uses ctlc_pkg.
module ctlc_front #(
    parameter int MAX_WORD_LENGTH = ctlc_pkg::DEFAULT_MAX_WORD_LENGTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_character,
    input  logic            i_end_of_text,
    output logic            o_push,
    output ctlc_pkg::t_entry o_entry
);
    import ctlc_pkg::*;

    localparam int LW = $clog2(MAX_WORD_LENGTH + 1);

    t_kw_word      r_kw, n_kw;
    logic [LW-1:0] r_len, n_len;
    logic          r_alld, n_alld;
    logic          r_dd, n_dd;
    logic [1:0]    r_dots, n_dots;
    logic          r_id, n_id;

    logic       w_delim;
    logic       w_close;
    logic       w_has_word;
    logic [4:0] w_sym;
    logic [3:0] w_kw_len;
    logic [7:0] w_sat_len;
    logic [3:0] w_class;

    generate
        if (LW > 8) begin : g_sat
            assign w_sat_len = (r_len > LW'(255)) ? 8'hFF : r_len[7:0];
        end else begin : g_nosat
            assign w_sat_len = 8'(r_len);
        end
    endgenerate

    assign w_delim    = is_delim(i_character);
    assign w_close    = i_end_of_text || w_delim;
    assign w_has_word = (r_len != '0);
    assign w_sym      = sym_kind(i_character);
    assign w_kw_len   = (r_len <= LW'(KEYWORD_BYTES)) ? r_len[3:0] : 4'd0;

    always_comb begin
        if (is_keyword(r_kw, w_kw_len)) begin
            w_class = CLASS_KEYWORD;
        end else if (r_dots == 2'd2) begin
            w_class = CLASS_MULTIDOT;
        end else if (r_alld) begin
            w_class = CLASS_INTEGER;
        end else if (r_dd) begin
            w_class = CLASS_FLOAT;
        end else if (r_id) begin
            w_class = CLASS_IDENT;
        end else begin
            w_class = CLASS_BAD_IDENT;
        end
    end

    always_comb begin
        o_entry.has_word   = w_has_word;
        o_entry.word_class = w_class;
        o_entry.word_len   = w_sat_len;
        o_entry.has_sym    = !i_end_of_text && w_sym[4];
        o_entry.sym_class  = w_sym[3:0];
        o_entry.sym        = i_character;
        o_push = i_accept && w_close && (w_has_word || o_entry.has_sym);
    end

    always_comb begin
        n_kw   = r_kw;
        n_len  = r_len;
        n_alld = r_alld;
        n_dd   = r_dd;
        n_dots = r_dots;
        n_id   = r_id;
        if (i_accept) begin
            if (w_close) begin
                n_kw   = '0;
                n_len  = '0;
                n_alld = 1'b1;
                n_dd   = 1'b1;
                n_dots = 2'd0;
                n_id   = 1'b1;
            end else begin
                for (int i = 0; i < KEYWORD_BYTES; i++) begin
                    if (r_len == LW'(i)) begin
                        n_kw[8*KEYWORD_BYTES-1-8*i -: 8] = i_character;
                    end
                end
                if (r_len == '0) begin
                    if (!is_letter(i_character)) begin
                        n_id = 1'b0;
                    end
                end else if (!is_letter(i_character) && !is_digit(i_character)) begin
                    n_id = 1'b0;
                end
                if (!is_digit(i_character)) begin
                    n_alld = 1'b0;
                end
                if (!is_digit(i_character) && i_character != ".") begin
                    n_dd = 1'b0;
                end
                if (i_character == "." && r_dots != 2'd2) begin
                    n_dots = r_dots + 2'd1;
                end
                if (r_len < LW'(MAX_WORD_LENGTH)) begin
                    n_len = r_len + LW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kw   <= '0;
            r_len  <= '0;
            r_alld <= 1'b1;
            r_dd   <= 1'b1;
            r_dots <= 2'd0;
            r_id   <= 1'b1;
        end else begin
            r_kw   <= n_kw;
            r_len  <= n_len;
            r_alld <= n_alld;
            r_dd   <= n_dd;
            r_dots <= n_dots;
            r_id   <= n_id;
        end
    end

endmodule

// File: rtl/ctlc_queue.sv
// Short queue of classified entries between front end and back end.
// Uses ctlc_pkg for the entry type and depth.
module ctlc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ctlc_pkg::t_entry i_entry,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_full,
    output ctlc_pkg::t_entry o_entry
);
    import ctlc_pkg::*;

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, r_rd;
    logic [QUEUE_AW:0]   r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QUEUE_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (QUEUE_AW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - (QUEUE_AW+1)'(1);
            end
        end
    end

endmodule

// File: rtl/ctlc_back.sv
// Back end: splits each queue entry into word and delimiter results and holds
// the oldest result in an output register. Uses ctlc_pkg.
module ctlc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  ctlc_pkg::t_entry i_q_entry,
    output logic             o_q_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [3:0]       o_token_class,
    output logic [7:0]       o_token_length,
    output logic [7:0]       o_symbol,
    output logic             o_last
);
    import ctlc_pkg::*;

    logic       r_valid;
    logic       r_phase;
    logic [3:0] r_class;
    logic [7:0] r_len;
    logic [7:0] r_sym;
    logic       r_last;

    logic       w_load;
    logic       w_word_part;
    logic       w_final;

    assign w_load      = i_q_valid && (!r_valid || i_pop);
    assign w_word_part = !r_phase && i_q_entry.has_word;
    assign w_final     = !w_word_part || !i_q_entry.has_sym;
    assign o_q_pop     = w_load && w_final;

    assign o_empty        = !r_valid;
    assign o_token_class  = r_class;
    assign o_token_length = r_len;
    assign o_symbol       = r_sym;
    assign o_last         = r_last;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_class <= w_word_part ? i_q_entry.word_class : i_q_entry.sym_class;
            r_len   <= w_word_part ? i_q_entry.word_len : 8'd1;
            r_sym   <= w_word_part ? 8'd0 : i_q_entry.sym;
            r_last  <= w_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_phase <= !w_final;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/c_subset_lexical_token_classifier_core.sv
// Top level of the C subset token classifier: front end, entry queue, back end.
// Depends on ctlc_pkg, ctlc_front, ctlc_queue and ctlc_back.
//
//   Channel   Handshake       Payload
//   input     push / full     i_character, i_end_of_text
//   result    empty / pop     o_token_class, o_token_length, o_symbol, o_last
//
// One character is taken per cycle while full is low; each transaction that closes a word and
// carries a reportable delimiter yields two results, word then delimiter, at the back end.
// Each result passes through the queue write and then the output register load.
// Reset is synchronous and active low.
// full rises when the four-entry queue is full; pop low stalls the back end and, once the queue fills, the input.
module c_subset_lexical_token_classifier_core #(
    parameter int MAX_WORD_LENGTH = ctlc_pkg::DEFAULT_MAX_WORD_LENGTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_character,
    input  logic       i_end_of_text,
    output logic       empty,
    input  logic       pop,
    output logic [3:0] o_token_class,
    output logic [7:0] o_token_length,
    output logic [7:0] o_symbol,
    output logic       o_last
);
    import ctlc_pkg::*;

    logic   w_accept;
    logic   w_f_push;
    t_entry w_f_entry;
    logic   w_q_valid;
    logic   w_q_pop;
    t_entry w_q_entry;

    assign w_accept = push && !full;

    ctlc_front #(
        .MAX_WORD_LENGTH(MAX_WORD_LENGTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_character   (i_character),
        .i_end_of_text (i_end_of_text),
        .o_push        (w_f_push),
        .o_entry       (w_f_entry)
    );

    ctlc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_push),
        .i_entry (w_f_entry),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_full  (full),
        .o_entry (w_q_entry)
    );

    ctlc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .i_q_entry      (w_q_entry),
        .o_q_pop        (w_q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_token_class  (o_token_class),
        .o_token_length (o_token_length),
        .o_symbol       (o_symbol),
        .o_last         (o_last)
    );

endmodule

// File: dv/lex_token_checker.sv
// Token checker for the C subset token classifier: follows the character stream,
// predicts the tokens each transaction should produce and compares the results.
// Depends on ctlc_pkg for the class codes.
`timescale 1ns / 1ps
module lex_token_checker #(
    parameter int MAX_WORD_LENGTH = ctlc_pkg::DEFAULT_MAX_WORD_LENGTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_full,
    input  logic [7:0] i_character,
    input  logic       i_end_of_text,
    input  logic       i_empty,
    input  logic       i_pop,
    input  logic [3:0] i_token_class,
    input  logic [7:0] i_token_length,
    input  logic [7:0] i_symbol,
    input  logic       i_last,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_tokens_checked,
    output logic [8:0] o_classes_seen
);
    import ctlc_pkg::*;

    localparam logic [7:0] NEWLINE = 8'h0A;

    typedef struct packed {
        logic [3:0] cls;
        logic [7:0] len;
        logic [7:0] sym;
        logic       last;
    } t_token;

    string keywords [KEYWORD_COUNT] = '{
        "if", "else", "while", "do", "break", "continue", "int", "double",
        "float", "return", "char", "case", "sizeof", "long", "short",
        "typedef", "switch", "unsigned", "void", "static", "struct", "goto"
    };

    t_token     expected_tokens[$];
    t_token     want;
    logic [7:0] word_buf [KEYWORD_BYTES];
    int         word_len;
    bit         all_digits;
    bit         digits_or_dots;
    bit         ident_ok;
    int         dots;

    task automatic report_error(input string msg);
        $display("ERROR %0t: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic clear_word();
        for (int i = 0; i < KEYWORD_BYTES; i++) begin
            word_buf[i] = 8'h00;
        end
        word_len       = 0;
        all_digits     = 1'b1;
        digits_or_dots = 1'b1;
        ident_ok       = 1'b1;
        dots           = 0;
    endtask

    function automatic bit keyword_hit();
        bit same;
        keyword_hit = 1'b0;
        if (word_len >= 1 && word_len <= KEYWORD_BYTES) begin
            for (int k = 0; k < KEYWORD_COUNT; k++) begin
                if (keywords[k].len() == word_len) begin
                    same = 1'b1;
                    for (int i = 0; i < word_len; i++) begin
                        if (word_buf[i] != keywords[k][i]) begin
                            same = 1'b0;
                        end
                    end
                    if (same) begin
                        keyword_hit = 1'b1;
                    end
                end
            end
        end
    endfunction

    function automatic logic [3:0] word_class();
        if (keyword_hit()) begin
            return CLASS_KEYWORD;
        end else if (dots >= 2) begin
            return CLASS_MULTIDOT;
        end else if (all_digits) begin
            return CLASS_INTEGER;
        end else if (digits_or_dots) begin
            return CLASS_FLOAT;
        end else if (ident_ok) begin
            return CLASS_IDENT;
        end
        return CLASS_BAD_IDENT;
    endfunction

    task automatic add_to_word(input logic [7:0] c);
        bit digit;
        bit alpha;
        digit = (c >= "0" && c <= "9");
        alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
        if (word_len < KEYWORD_BYTES) begin
            word_buf[word_len] = c;
        end
        if (word_len == 0 ? !alpha : !(alpha || digit)) begin
            ident_ok = 1'b0;
        end
        if (!digit) begin
            all_digits = 1'b0;
        end
        if (!digit && c != ".") begin
            digits_or_dots = 1'b0;
        end
        if (c == "." && dots < 2) begin
            dots++;
        end
        if (word_len < MAX_WORD_LENGTH) begin
            word_len++;
        end
    endtask

    task automatic classify_byte(input logic [7:0] c, input logic eot);
        t_token     toks [2];
        int         n;
        bit         closes;
        bit         has_sym;
        logic [3:0] sym_cls;
        n       = 0;
        closes  = 1'b0;
        has_sym = 1'b0;
        sym_cls = CLASS_KEYWORD;
        if (eot) begin
            closes = 1'b1;
        end else begin
            case (c)
                "+", "-", "*", "/": begin
                    closes  = 1'b1;
                    has_sym = 1'b1;
                    sym_cls = CLASS_ARITH;
                end
                "<", ">", "=": begin
                    closes  = 1'b1;
                    has_sym = 1'b1;
                    sym_cls = CLASS_RELATIONAL;
                end
                ",", ";", "(", ")", "{", "}": begin
                    closes  = 1'b1;
                    has_sym = 1'b1;
                    sym_cls = CLASS_SEPARATOR;
                end
                " ", NEWLINE, "[", "]": begin
                    closes = 1'b1;
                end
                default: begin
                    add_to_word(c);
                end
            endcase
        end
        if (closes && word_len > 0) begin
            toks[n] = '{word_class(), (word_len > 255) ? 8'd255 : 8'(word_len), 8'h00, 1'b0};
            n++;
            clear_word();
        end
        if (has_sym) begin
            toks[n] = '{sym_cls, 8'd1, c, 1'b0};
            n++;
        end
        if (n > 0) begin
            toks[n-1].last = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            expected_tokens.insert(expected_tokens.size(), toks[i]);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_word();
            expected_tokens.delete();
            o_fail_count     = 0;
            o_tokens_checked = 0;
            o_classes_seen   = '0;
        end else begin
            if (!i_empty && i_pop) begin
                if (expected_tokens.size() == 0) begin
                    report_error($sformatf("token class %0d length %0d with none expected",
                                           i_token_class, i_token_length));
                end else begin
                    want = expected_tokens.pop_front();
                    if (i_token_class !== want.cls) begin
                        report_error($sformatf("token %0d class %0d, expected %0d",
                                               o_tokens_checked, i_token_class, want.cls));
                    end
                    if (i_token_length !== want.len) begin
                        report_error($sformatf("token %0d length %0d, expected %0d",
                                               o_tokens_checked, i_token_length, want.len));
                    end
                    if (i_symbol !== want.sym) begin
                        report_error($sformatf("token %0d symbol %0h, expected %0h",
                                               o_tokens_checked, i_symbol, want.sym));
                    end
                    if (i_last !== want.last) begin
                        report_error($sformatf("token %0d last %0b, expected %0b",
                                               o_tokens_checked, i_last, want.last));
                    end
                end
                if (i_token_class <= CLASS_SEPARATOR) begin
                    o_classes_seen[i_token_class] = 1'b1;
                end
                o_tokens_checked++;
            end
            if (i_push && !i_full) begin
                classify_byte(i_character, i_end_of_text);
            end
        end
        o_pending = expected_tokens.size();
    end

endmodule

// File: dv/tb_top.sv
// Testbench top for the C subset token classifier: clock, reset, character
// stimulus, result draining and the verdict. Depends on ctlc_pkg, the core
// and lex_token_checker.
`timescale 1ns / 1ps
module tb_top;

    localparam int ITEM_TARGET = 1800;
    localparam int IDLE_LIMIT  = 3000;
    localparam int HOLD_AT     = 600;
    localparam int HOLD_LEN    = 120;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       push          = 1'b0;
    logic [7:0] i_character   = 8'h00;
    logic       i_end_of_text = 1'b0;
    logic       pop           = 1'b0;
    logic       full;
    logic       empty;
    logic [3:0] o_token_class;
    logic [7:0] o_token_length;
    logic [7:0] o_symbol;
    logic       o_last;

    int         fail_count;
    int         pending;
    int         tokens_checked;
    logic [8:0] classes_seen;

    int         chars_sent  = 0;
    int         idle_cycles = 0;
    int         word_idx    = 0;
    bit         burst       = 1'b0;
    bit         rx_holding  = 1'b0;
    bit         hold_done   = 1'b0;
    logic [7:0] word_chars[$];

    string keywords [22] = '{
        "if", "else", "while", "do", "break", "continue", "int", "double",
        "float", "return", "char", "case", "sizeof", "long", "short",
        "typedef", "switch", "unsigned", "void", "static", "struct", "goto"
    };
    string delims = " \n+-*/,;<>=()[]{}";

    c_subset_lexical_token_classifier_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_character   (i_character),
        .i_end_of_text (i_end_of_text),
        .empty         (empty),
        .pop           (pop),
        .o_token_class (o_token_class),
        .o_token_length(o_token_length),
        .o_symbol      (o_symbol),
        .o_last        (o_last)
    );

    lex_token_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_full          (full),
        .i_character     (i_character),
        .i_end_of_text   (i_end_of_text),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_token_class   (o_token_class),
        .i_token_length  (o_token_length),
        .i_symbol        (o_symbol),
        .i_last          (o_last),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_tokens_checked(tokens_checked),
        .o_classes_seen  (classes_seen)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("simulation failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26) begin
            return 8'("a" + r);
        end else if (r < 52) begin
            return 8'("A" + r - 26);
        end
        return "_";
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    task automatic append_char(input logic [7:0] c);
        word_chars.insert(word_chars.size(), c);
    endtask

    task automatic send_item(input logic [7:0] c, input logic eot);
        int r;
        int n;
        n = 0;
        if (!burst && !rx_holding) begin
            r = $urandom_range(0, 99);
            if (r >= 94) begin
                n = $urandom_range(8, 30);
            end else if (r >= 70) begin
                n = $urandom_range(1, 3);
            end
        end
        if (n > 0) begin
            push <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        push          <= 1'b1;
        i_character   <= c;
        i_end_of_text <= eot;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_item(s[i], 1'b0);
        end
    endtask

    task automatic make_word(input int kind);
        string s;
        int    n;
        int    m;
        word_chars.delete();
        case (kind)
            0, 1: begin
                s = keywords[$urandom_range(0, 21)];
                for (int i = 0; i < s.len(); i++) begin
                    append_char(s[i]);
                end
                if (kind == 1) begin
                    m = $urandom_range(0, 2);
                    if (m == 0) begin
                        void'(word_chars.pop_back());
                    end else if (m == 1) begin
                        append_char(rand_letter());
                    end else begin
                        word_chars[$urandom_range(0, word_chars.size() - 1)] = rand_letter();
                    end
                end
            end
            2: begin
                n = $urandom_range(1, 6);
                repeat (n) append_char(rand_digit());
            end
            3: begin
                repeat ($urandom_range(0, 4)) append_char(rand_digit());
                append_char(".");
                repeat ($urandom_range(0, 4)) append_char(rand_digit());
            end
            4: begin
                n = $urandom_range(2, 4);
                repeat (n) begin
                    repeat ($urandom_range(0, 2)) begin
                        append_char($urandom_range(0, 3) == 0 ? rand_letter()
                                                              : rand_digit());
                    end
                    append_char(".");
                end
            end
            5: begin
                append_char(rand_letter());
                repeat ($urandom_range(0, 10)) begin
                    append_char($urandom_range(0, 2) == 0 ? rand_digit()
                                                          : rand_letter());
                end
            end
            6: begin
                if ($urandom_range(0, 1) == 0) begin
                    append_char(rand_digit());
                    repeat ($urandom_range(1, 5)) append_char(rand_letter());
                end else begin
                    repeat ($urandom_range(0, 4)) append_char(rand_letter());
                    word_chars.insert($urandom_range(0, word_chars.size()),
                                      8'($urandom_range(0, 255)));
                end
            end
            7: begin
                n = $urandom_range(250, 262);
                repeat (n) begin
                    m = $urandom_range(0, 9);
                    append_char(m < 6 ? rand_letter() : (m < 9 ? rand_digit() : "."));
                end
            end
            default: begin
                repeat ($urandom_range(1, 4)) append_char(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    task automatic send_delimiter();
        if ($urandom_range(0, 99) < 6) begin
            send_item(8'($urandom_range(0, 255)), 1'b1);
        end else begin
            send_item(delims[$urandom_range(0, delims.len() - 1)], 1'b0);
        end
    endtask

    // receiver: random pop pattern with one long hold-off to fill the core
    initial begin
        int n;
        int r;
        int rx_cycles;
        rx_cycles = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            r = $urandom_range(0, 99);
            if (!hold_done && rx_cycles >= HOLD_AT) begin
                rx_holding = 1'b1;
                pop <= 1'b0;
                n = HOLD_LEN;
            end else if (r < 55) begin
                pop <= 1'b1;
                n = $urandom_range(1, 40);
            end else if (r < 92) begin
                pop <= 1'b0;
                n = $urandom_range(1, 3);
            end else begin
                pop <= 1'b0;
                n = $urandom_range(10, 40);
            end
            repeat (n) @(posedge i_clk);
            rx_cycles += n;
            if (rx_holding) begin
                rx_holding = 1'b0;
                hold_done  = 1'b1;
            end
        end
    end

    initial begin
        int r;
        int kind;
        i_rst_n <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every delimiter, each word class, a zero byte and a flush at the end marker
        send_text("do ..,7=.;a/");
        send_item(8'h00, 1'b0);
        send_text("{}[]\n(<>)-*+if");
        send_item(8'($urandom_range(0, 255)), 1'b1);

        while (chars_sent < ITEM_TARGET) begin
            burst = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 199);
            if (word_idx == 30 || r == 0) begin
                kind = 7;
            end else if (r < 30) begin
                kind = 0;
            end else if (r < 50) begin
                kind = 1;
            end else if (r < 76) begin
                kind = 2;
            end else if (r < 100) begin
                kind = 3;
            end else if (r < 116) begin
                kind = 4;
            end else if (r < 156) begin
                kind = 5;
            end else if (r < 176) begin
                kind = 6;
            end else begin
                kind = 8;
            end
            make_word(kind);
            foreach (word_chars[i]) begin
                send_item(word_chars[i], 1'b0);
            end
            send_delimiter();
            if ($urandom_range(0, 5) == 0) begin
                send_delimiter();
            end
            word_idx++;
        end

        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("%0d characters in %0d random words, %0d tokens checked, classes seen %b",
                 chars_sent, word_idx, tokens_checked, classes_seen);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: c_subset_lexical_token_classifier_core.f
rtl/ctlc_pkg.sv
rtl/ctlc_front.sv
rtl/ctlc_queue.sv
rtl/ctlc_back.sv
rtl/c_subset_lexical_token_classifier_core.sv
dv/lex_token_checker.sv
dv/tb_top.sv
